### sv/cfd_pkg.sv
// Package for the control frame deframer.
// Holds the beat structs, stage control struct and the frame constants.
// No dependencies.
package cfd_pkg;

  localparam int PosW = 17;
  localparam logic [PosW-1:0] POS_MAX = '1;
  localparam logic [PosW-1:0] POS_TYPE = 17'd4;
  localparam logic [PosW-1:0] POS_LEN_HI = 17'd5;
  localparam logic [PosW-1:0] POS_LEN_LO = 17'd6;
  localparam logic [PosW-1:0] POS_SRC_FIRST = 17'd7;
  localparam logic [PosW-1:0] POS_SRC_LAST = 17'd10;
  localparam logic [PosW-1:0] POS_DST_FIRST = 17'd11;
  localparam logic [PosW-1:0] POS_DST_LAST = 17'd14;
  localparam logic [PosW-1:0] POS_PAYLOAD = 17'd15;
  localparam logic [PosW-1:0] HDR_LEN = 17'd4;
  localparam logic [PosW-1:0] MIN_FRAME = 17'h10;

  localparam logic [7:0] HDR_EVEN = 8'h44; // 'D'
  localparam logic [7:0] HDR_ODD = 8'h53;  // 'S'

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_HEADER = 2'd1;
  localparam logic [1:0] ST_BAD_LENGTH = 2'd2;
  localparam logic [1:0] ST_BAD_CHECKSUM = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic last_byte;
  } frame_beat_t;

  typedef struct packed {
    logic kind;
    logic [7:0] payload_byte;
    logic [1:0] status;
    logic [3:0] message_type;
    logic [1:0] data_kind;
    logic [1:0] device_kind;
    logic [31:0] source_id;
    logic [31:0] dest_id;
    logic [15:0] payload_len;
  } result_beat_t;

  // Handshake between the input register and the frame logic.
  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctl_t;

endpackage

### sv/cfd_input_reg.sv
// Input register stage of the control frame deframer.
// Captures one frame beat and holds it until the next stage takes it.
// Depends on cfd_pkg.
module cfd_input_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                frame_valid,
  output logic                frame_stall,
  input  cfd_pkg::frame_beat_t frame,
  input  logic                take,
  output logic                beat_valid,
  output cfd_pkg::frame_beat_t beat
);
  import cfd_pkg::*;

  logic load;

  assign frame_stall = beat_valid && !take;
  assign load = frame_valid && !frame_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (load) begin
      beat_valid <= 1'b1;
    end else if (take) begin
      beat_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat <= frame;
    end
  end

endmodule

### sv/cfd_frame_logic.sv
// Frame tracking state and per-byte decode of the control frame deframer.
// Checks the header, captures fields, sums bytes and forms each result beat.
// Depends on cfd_pkg.
module cfd_frame_logic (
  input  logic                 clk,
  input  logic                 rst,
  input  cfd_pkg::stage_ctl_t  ctl,
  input  cfd_pkg::frame_beat_t beat,
  output logic                 has_result,
  output cfd_pkg::result_beat_t result
);
  import cfd_pkg::*;

  logic [PosW-1:0] byte_position;
  logic [PosW-1:0] byte_position_next;
  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic header_good;
  logic header_good_next;
  logic [15:0] declared_length;
  logic [15:0] declared_length_next;
  logic [7:0] type_byte;
  logic [7:0] type_byte_next;
  logic [31:0] source_reg;
  logic [31:0] source_reg_next;
  logic [31:0] dest_reg;
  logic [31:0] dest_reg_next;

  logic [7:0] want;
  logic hdr_ok;
  logic [PosW-1:0] count;
  logic [PosW:0] end_pos;
  logic in_payload;
  logic [1:0] st;

  always_comb begin
    want = byte_position[0] ? HDR_ODD : HDR_EVEN;
    hdr_ok = header_good && ((byte_position >= HDR_LEN) || (beat.data_byte == want));
    count = (byte_position == POS_MAX) ? byte_position : byte_position + 1'b1;
    end_pos = {1'b0, byte_position} + 18'd2;
    in_payload = hdr_ok && (byte_position >= POS_PAYLOAD)
                 && (end_pos <= {2'b00, declared_length});

    if (!hdr_ok || (count < HDR_LEN)) begin
      st = ST_BAD_HEADER;
    end else if ((count < MIN_FRAME) || (count != {1'b0, declared_length})) begin
      st = ST_BAD_LENGTH;
    end else if (running_sum != beat.data_byte) begin
      st = ST_BAD_CHECKSUM;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    result = '0;
    if (beat.last_byte) begin
      has_result = 1'b1;
      result.kind = KIND_STATUS;
      result.status = st;
      if (st == ST_OK) begin
        result.message_type = type_byte[7:4];
        result.data_kind = type_byte[3:2];
        result.device_kind = type_byte[1:0];
        result.source_id = source_reg;
        result.dest_id = dest_reg;
        result.payload_len = declared_length - MIN_FRAME[15:0];
      end
    end else begin
      has_result = in_payload;
      result.kind = KIND_PAYLOAD;
      result.payload_byte = beat.data_byte;
    end
  end

  always_comb begin
    byte_position_next = byte_position;
    running_sum_next = running_sum;
    header_good_next = hdr_ok;
    declared_length_next = declared_length;
    type_byte_next = type_byte;
    source_reg_next = source_reg;
    dest_reg_next = dest_reg;
    if (beat.last_byte) begin
      // end of frame: back to the reset picture
      byte_position_next = '0;
      running_sum_next = '0;
      header_good_next = 1'b1;
      declared_length_next = '0;
      type_byte_next = '0;
      source_reg_next = '0;
      dest_reg_next = '0;
    end else begin
      byte_position_next = count;
      running_sum_next = running_sum + beat.data_byte;
      if (byte_position == POS_TYPE) begin
        type_byte_next = beat.data_byte;
      end else if (byte_position == POS_LEN_HI) begin
        declared_length_next = {beat.data_byte, declared_length[7:0]};
      end else if (byte_position == POS_LEN_LO) begin
        declared_length_next = {declared_length[15:8], beat.data_byte};
      end else if ((byte_position >= POS_SRC_FIRST) && (byte_position <= POS_SRC_LAST)) begin
        source_reg_next = {source_reg[23:0], beat.data_byte};
      end else if ((byte_position >= POS_DST_FIRST) && (byte_position <= POS_DST_LAST)) begin
        dest_reg_next = {dest_reg[23:0], beat.data_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_sum <= '0;
      header_good <= 1'b1;
      declared_length <= '0;
      type_byte <= '0;
      source_reg <= '0;
      dest_reg <= '0;
    end else if (ctl.valid && ctl.take) begin
      byte_position <= byte_position_next;
      running_sum <= running_sum_next;
      header_good <= header_good_next;
      declared_length <= declared_length_next;
      type_byte <= type_byte_next;
      source_reg <= source_reg_next;
      dest_reg <= dest_reg_next;
    end
  end

endmodule

### sv/cfd_output_reg.sv
// Result register of the control frame deframer.
// Holds one result beat until the receiver takes it; loads in the same cycle.
// Depends on cfd_pkg.
module cfd_output_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  cfd_pkg::result_beat_t next_result,
  output logic                  can_load,
  output logic                  result_valid,
  input  logic                  result_stall,
  output cfd_pkg::result_beat_t result
);
  import cfd_pkg::*;

  assign can_load = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (can_load) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      result <= next_result;
    end
  end

endmodule

### sv/control_frame_deframer.sv
// Top level of the control frame deframer.
// Chains input register, frame logic and result register. Depends on cfd_pkg.
//
// Usage:
//   frame carries one received byte a beat, last_byte set on the final byte.
//   result carries either a payload byte (kind 0) or one end-of-frame status
//   beat (kind 1) with the decoded type fields, ids and payload length.
//   A beat moves on a rising edge with valid high and stall low.
// Path: a byte accepted into the input register gives its result beat, if any,
//   in the result register, which a held result can delay.
// Throughput: one byte per cycle while no held result stalls the input, set
//   by the single pass of byte logic between the two registers; header bytes
//   and bytes past the payload give no result.
// Reset: rst clears both stage valids and returns the frame state to the
//   start of a frame (position zero, sum zero, header good).
// Stall: while result_stall holds a waiting result, the next byte still
//   fills the input register; frame_stall rises only when both are full.
module control_frame_deframer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  frame_valid,
  output logic                  frame_stall,
  input  cfd_pkg::frame_beat_t  frame,
  output logic                  result_valid,
  input  logic                  result_stall,
  output cfd_pkg::result_beat_t result
);
  import cfd_pkg::*;

  stage_ctl_t ctl;
  frame_beat_t beat;
  result_beat_t next_result;
  logic beat_valid;
  logic has_result;
  logic can_load;

  assign ctl = '{valid: beat_valid, take: can_load};

  cfd_input_reg u_input_reg (
    .clk        (clk),
    .rst        (rst),
    .frame_valid(frame_valid),
    .frame_stall(frame_stall),
    .frame      (frame),
    .take       (can_load),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  cfd_frame_logic u_frame_logic (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .beat      (beat),
    .has_result(has_result),
    .result    (next_result)
  );

  cfd_output_reg u_output_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (ctl.valid && has_result),
    .next_result (next_result),
    .can_load    (can_load),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  // input side blocks only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    frame_stall |-> (result_valid && result_stall))
    else $error("frame_stall without a held result");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result_valid after reset");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.kind == KIND_PAYLOAD)) |->
      ((result.status == ST_OK) && (result.payload_len == 16'd0)
       && (result.source_id == 32'd0) && (result.dest_id == 32'd0)))
    else $error("payload beat carries status fields");

  a_bad_status_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.kind == KIND_STATUS) && (result.status != ST_OK)) |->
      ((result.source_id == 32'd0) && (result.dest_id == 32'd0)
       && (result.payload_len == 16'd0) && (result.message_type == 4'd0)))
    else $error("failed frame reports decoded fields");

endmodule

### verif/tb_control_frame_deframer.sv
// Self-checking testbench for control_frame_deframer: byte-serial frames in,
// payload and end-of-frame status beats out, compared against a built-in
// frame decoder. Depends on cfd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb_control_frame_deframer;
  import cfd_pkg::*;

  localparam int LIMIT = 50_000;
  localparam int HOLD_CYCLES = 300;

  class deframe_scoreboard;
    logic [PosW-1:0] pos;
    logic [7:0] sum;
    logic hdr_ok;
    logic [15:0] decl_len;
    logic [7:0] type_byte;
    logic [31:0] src;
    logic [31:0] dst;
    result_beat_t due_beats[$];
    int mismatches;
    int payload_checked;
    int status_checked;
    int status_count[4];

    function new();
      restart();
    endfunction

    function void restart();
      pos = '0;
      sum = '0;
      hdr_ok = 1'b1;
      decl_len = '0;
      type_byte = '0;
      src = '0;
      dst = '0;
    endfunction

    function string show(result_beat_t r);
      return $sformatf("kind=%0d byte=%02h status=%0d type=%h/%0d/%0d src=%08h dst=%08h len=%0d",
                       r.kind, r.payload_byte, r.status, r.message_type, r.data_kind,
                       r.device_kind, r.source_id, r.dest_id, r.payload_len);
    endfunction

    // Advance the frame decoder by one accepted byte and queue what it yields.
    function void take_byte(frame_beat_t fb);
      logic [PosW-1:0] p;
      logic [PosW-1:0] cnt;
      logic [7:0] b;
      logic [1:0] st;
      int reach;
      result_beat_t r;
      p = pos;
      b = fb.data_byte;
      r = '0;
      if (p < HDR_LEN && b != (p[0] ? HDR_ODD : HDR_EVEN)) hdr_ok = 1'b0;
      if (p == POS_TYPE) type_byte = b;
      else if (p == POS_LEN_HI) decl_len[15:8] = b;
      else if (p == POS_LEN_LO) decl_len[7:0] = b;
      else if (p >= POS_SRC_FIRST && p <= POS_SRC_LAST) src = {src[23:0], b};
      else if (p >= POS_DST_FIRST && p <= POS_DST_LAST) dst = {dst[23:0], b};

      if (!fb.last_byte) begin
        sum = sum + b;
        if (pos != POS_MAX) pos = pos + 1'b1;
        reach = int'(p) + 2;
        if (hdr_ok && p >= POS_PAYLOAD && reach <= int'(decl_len)) begin
          r.kind = KIND_PAYLOAD;
          r.payload_byte = b;
          due_beats.push_back(r);
        end
        return;
      end

      cnt = (p != POS_MAX) ? p + 1'b1 : POS_MAX;
      if (!hdr_ok || cnt < HDR_LEN) st = ST_BAD_HEADER;
      else if (cnt < MIN_FRAME || cnt != {1'b0, decl_len}) st = ST_BAD_LENGTH;
      else if (sum != b) st = ST_BAD_CHECKSUM;
      else st = ST_OK;
      r.kind = KIND_STATUS;
      r.status = st;
      if (st == ST_OK) begin
        r.message_type = type_byte[7:4];
        r.data_kind = type_byte[3:2];
        r.device_kind = type_byte[1:0];
        r.source_id = src;
        r.dest_id = dst;
        r.payload_len = decl_len - 16'd16;
      end
      status_count[st]++;
      due_beats.push_back(r);
      restart();
    endfunction

    function void check_result(result_beat_t got);
      result_beat_t want;
      if (due_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with nothing due: %s", show(got));
        return;
      end
      want = due_beats.pop_front();
      if (got.kind != want.kind || got.payload_byte != want.payload_byte ||
          got.status != want.status || got.message_type != want.message_type ||
          got.data_kind != want.data_kind || got.device_kind != want.device_kind ||
          got.source_id != want.source_id || got.dest_id != want.dest_id ||
          got.payload_len != want.payload_len) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected %s", show(want));
          $display("          actual   %s", show(got));
        end
      end else if (got.kind == KIND_STATUS) begin
        status_checked++;
      end else begin
        payload_checked++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic frame_valid = 1'b0;
  logic frame_stall;
  frame_beat_t frame = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_beat_t result;

  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit hold_rx = 1'b0;
  bit pressure_go = 1'b0;
  int cycles = 0;
  int frames_sent = 0;
  int bytes_sent = 0;
  logic [7:0] tx_bytes[$];
  deframe_scoreboard sb;

  control_frame_deframer u_dut (
    .clk(clk),
    .rst(rst),
    .frame_valid(frame_valid),
    .frame_stall(frame_stall),
    .frame(frame),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timed out after %0d cycles", cycles);
      $display("[control_frame_deframer] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && frame_valid && !frame_stall) sb.take_byte(frame);
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  always @(posedge clk)
    result_stall <= hold_rx || (!rx_calm && $urandom_range(0, 99) < 32);

  // Hold the receiver off long enough for the block to back up into its input.
  initial begin
    wait (pressure_go);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Build a frame in tx_bytes: DSDS header, declared length, random or filled
  // body, checksum last. Optionally corrupt one header byte, the checksum, or both.
  task automatic make_frame(input int n, input logic [15:0] decl, input bit hdr_bad,
                            input bit sum_bad, input int fill);
    logic [7:0] s;
    logic [7:0] b;
    int i;
    int k;
    tx_bytes.delete();
    s = '0;
    for (i = 0; i < n; i++) begin
      if (i < 4) b = i[0] ? HDR_ODD : HDR_EVEN;
      else if (i == 5) b = decl[15:8];
      else if (i == 6) b = decl[7:0];
      else if (fill >= 0) b = fill[7:0];
      else b = 8'($urandom_range(0, 255));
      tx_bytes.push_back(b);
    end
    if (hdr_bad) begin
      k = $urandom_range(0, (n < 4 ? n : 4) - 1);
      tx_bytes[k] = tx_bytes[k] ^ 8'($urandom_range(1, 255));
    end
    for (i = 0; i < n - 1; i++) s = s + tx_bytes[i];
    tx_bytes[n-1] = sum_bad ? s + 8'($urandom_range(1, 255)) : s;
  endtask

  task automatic send_byte(input logic [7:0] d, input logic l);
    while (!tx_calm && $urandom_range(0, 99) < 32) begin
      frame_valid <= 1'b0;
      @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame <= '{data_byte: d, last_byte: l};
    @(posedge clk);
    while (frame_stall) @(posedge clk);
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < tx_bytes.size(); i++) send_byte(tx_bytes[i], i == tx_bytes.size() - 1);
    frames_sent++;
    bytes_sent += tx_bytes.size();
  endtask

  initial begin
    int n;
    int roll;
    int i;
    int random_bytes;
    logic [15:0] decl;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // All-ones fields, a lone final byte, and a frame shorter than its header.
    make_frame(16, 16'd16, 1'b0, 1'b0, 8'hFF);
    send_frame();
    make_frame(1, 16'd0, 1'b0, 1'b0, -1);
    send_frame();
    make_frame(3, 16'd3, 1'b0, 1'b0, -1);
    send_frame();

    random_bytes = 0;
    while (random_bytes < 580) begin
      if (frames_sent == 15) begin
        tx_calm <= 1'b1;
        rx_calm <= 1'b1;
      end else if (frames_sent == 35) begin
        tx_calm <= 1'b0;
        rx_calm <= 1'b0;
      end
      roll = $urandom_range(0, 99);
      n = 16 + $urandom_range(0, 24);
      if (roll < 55) begin
        make_frame(n, 16'(n), 1'b0, 1'b0, -1);
      end else if (roll < 62) begin
        make_frame(n, 16'(n), 1'b0, 1'b1, -1);
      end else if (roll < 70) begin
        // declared length off by a little either way; longer leaves the
        // checksum inside the payload range
        decl = 16'(n + ($urandom_range(0, 1) ? $urandom_range(1, 6) : -$urandom_range(1, 6)));
        make_frame(n, decl, 1'b0, 1'($urandom_range(0, 1)), -1);
      end else if (roll < 76) begin
        n = $urandom_range(1, 15);
        make_frame(n, $urandom_range(0, 1) ? 16'(n) : 16'($urandom_range(0, 65535)),
                   1'($urandom_range(0, 1)), 1'b0, -1);
      end else if (roll < 84) begin
        make_frame(n, 16'(n), 1'b1, 1'($urandom_range(0, 1)), -1);
      end else if (roll < 90) begin
        n = $urandom_range(5, 40);
        make_frame(n, 16'($urandom_range(0, 65535)), 1'b0, 1'b0, -1);
      end else begin
        n = $urandom_range(1, 30);
        make_frame(n, 16'(n), 1'b0, 1'b0, -1);
        for (i = 0; i < n; i++) tx_bytes[i] = 8'($urandom_range(0, 255));
      end
      random_bytes += n;
      send_frame();
    end

    // Back-pressure: sender streams with no gaps while the receiver holds off.
    tx_calm <= 1'b1;
    pressure_go <= 1'b1;
    make_frame(200, 16'd200, 1'b0, 1'b0, -1);
    send_frame();
    tx_calm <= 1'b0;
    frame_valid <= 1'b0;

    while (sb.due_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.due_beats.size() != 0) begin
      sb.mismatches += sb.due_beats.size();
      $display("%0d result beats never arrived", sb.due_beats.size());
    end

    $display("sent %0d frames in %0d bytes; checked %0d payload and %0d status beats",
             frames_sent, bytes_sent, sb.payload_checked, sb.status_checked);
    $display("status outcomes: ok %0d, header %0d, length %0d, checksum %0d; %0d mismatches",
             sb.status_count[ST_OK], sb.status_count[ST_BAD_HEADER],
             sb.status_count[ST_BAD_LENGTH], sb.status_count[ST_BAD_CHECKSUM], sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[control_frame_deframer] OK");
    end else begin
      $display("[control_frame_deframer] ERROR");
    end
    $finish;
  end

endmodule
